// ----- rtl/brbf_pkg.sv -----
// Package for the byte ring buffer FIFO: sizes, command codes, control types.
// Used by the interfaces and by every module of the block.
`default_nettype none

package brbf_pkg;

  // Buffer geometry
  localparam int unsigned DEPTH     = 256;
  localparam int unsigned MAX_BURST = 64;

  // Field widths fixed by the item format
  localparam int unsigned CMD_W  = 2;
  localparam int unsigned DATA_W = 8;
  localparam int unsigned REQ_W  = 7;
  localparam int unsigned CNT_W  = 9;

  // Internal widths derived from the geometry
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned OCC_W = $clog2(DEPTH + 1);
  localparam int unsigned REM_W = (MAX_BURST > 1) ? $clog2(MAX_BURST) : 1;
  localparam int unsigned CMP_W = (OCC_W > REQ_W) ? OCC_W : REQ_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE  = 2'd0,
    CMD_READ   = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_STATUS = 2'd3
  } cmd_e;

  // Kind of result loaded into the output register
  typedef enum logic [1:0] {
    OK_WRITE,
    OK_PLAIN,
    OK_CLEAR,
    OK_BYTE
  } out_kind_e;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic      load_out;
    out_kind_e out_kind;
    logic      do_write;
    logic      start_read;
    logic      do_fetch;
    logic      do_clear;
  } ctrl_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic slot_free;
    logic grant_zero;
    logic remain_zero;
  } dp_status_t;

  // Advance a buffer pointer, wrapping at the depth
  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] n;
    if (p == PTR_W'(DEPTH - 1)) begin
      n = '0;
    end else begin
      n = p + PTR_W'(1);
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/brbf_if.sv -----
// Valid/ready channel interfaces for command items and result items.
// Depends on brbf_pkg for field widths.
`default_nettype none

interface brbf_in_if;
  logic                           valid;
  logic                           ready;
  logic [brbf_pkg::CMD_W-1:0]     command;
  logic [brbf_pkg::DATA_W-1:0]    data_byte;
  logic [brbf_pkg::REQ_W-1:0]     read_count;

  modport source (output valid, output command, output data_byte, output read_count,
                  input ready);
  modport sink   (input valid, input command, input data_byte, input read_count,
                  output ready);
endinterface

interface brbf_out_if;
  logic                           valid;
  logic                           ready;
  logic [brbf_pkg::DATA_W-1:0]    read_byte;
  logic                           byte_valid;
  logic                           last;
  logic                           accepted;
  logic [brbf_pkg::REQ_W-1:0]     moved_count;
  logic [brbf_pkg::CNT_W-1:0]     stored_count;

  modport source (output valid, output read_byte, output byte_valid, output last,
                  output accepted, output moved_count, output stored_count,
                  input ready);
  modport sink   (input valid, input read_byte, input byte_valid, input last,
                  input accepted, input moved_count, input stored_count,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/brbf_ctrl.sv -----
// Controller of the byte ring buffer: accepts command items and sequences bursts.
// Depends on brbf_pkg; drives the datapath through ctrl_cmd_t.
`default_nettype none

module brbf_ctrl (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  input  wire logic [brbf_pkg::CMD_W-1:0] in_command_i,
  output logic                            in_ready_o,
  input  wire brbf_pkg::dp_status_t       status_i,
  output brbf_pkg::ctrl_cmd_t             cmd_o
);

  brbf_pkg::state_e state_q, state_d;
  brbf_pkg::cmd_e   command;
  logic             take;

  assign command    = brbf_pkg::cmd_e'(in_command_i);
  assign in_ready_o = (state_q == brbf_pkg::ST_IDLE) && status_i.slot_free;
  assign take       = in_valid_i && in_ready_o;

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= brbf_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      brbf_pkg::ST_IDLE: begin
        if (take && (command == brbf_pkg::CMD_READ) && !status_i.grant_zero) begin
          state_d = brbf_pkg::ST_READ;
        end
      end
      brbf_pkg::ST_READ: begin
        if (status_i.slot_free && status_i.remain_zero) begin
          state_d = brbf_pkg::ST_IDLE;
        end
      end
      default: state_d = brbf_pkg::ST_IDLE;
    endcase
  end

  // Datapath commands
  always_comb begin
    cmd_o = '0;
    cmd_o.out_kind = brbf_pkg::OK_PLAIN;
    unique case (state_q)
      brbf_pkg::ST_IDLE: begin
        if (take) begin
          unique case (command)
            brbf_pkg::CMD_WRITE: begin
              cmd_o.do_write = 1'b1;
              cmd_o.load_out = 1'b1;
              cmd_o.out_kind = brbf_pkg::OK_WRITE;
            end
            brbf_pkg::CMD_READ: begin
              if (status_i.grant_zero) begin
                cmd_o.load_out = 1'b1;
              end else begin
                cmd_o.start_read = 1'b1;
                cmd_o.do_fetch   = 1'b1;
              end
            end
            brbf_pkg::CMD_CLEAR: begin
              cmd_o.do_clear = 1'b1;
              cmd_o.load_out = 1'b1;
              cmd_o.out_kind = brbf_pkg::OK_CLEAR;
            end
            brbf_pkg::CMD_STATUS: begin
              cmd_o.load_out = 1'b1;
            end
            default: cmd_o.load_out = 1'b1;
          endcase
        end
      end
      brbf_pkg::ST_READ: begin
        // Emit the fetched byte and fetch the next while bytes remain
        if (status_i.slot_free) begin
          cmd_o.load_out = 1'b1;
          cmd_o.out_kind = brbf_pkg::OK_BYTE;
          cmd_o.do_fetch = !status_i.remain_zero;
        end
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/brbf_dp.sv -----
// Datapath of the byte ring buffer: byte memory, pointers, occupancy, output register.
// Depends on brbf_pkg; obeys ctrl_cmd_t from the controller.
`default_nettype none

module brbf_dp (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire brbf_pkg::ctrl_cmd_t         cmd_i,
  output brbf_pkg::dp_status_t             status_o,
  input  wire logic [brbf_pkg::DATA_W-1:0] data_byte_i,
  input  wire logic [brbf_pkg::REQ_W-1:0]  read_count_i,
  input  wire logic                        out_ready_i,
  output logic                             out_valid_o,
  output logic [brbf_pkg::DATA_W-1:0]      read_byte_o,
  output logic                             byte_valid_o,
  output logic                             last_o,
  output logic                             accepted_o,
  output logic [brbf_pkg::REQ_W-1:0]       moved_count_o,
  output logic [brbf_pkg::CNT_W-1:0]       stored_count_o
);

  logic [brbf_pkg::DATA_W-1:0] mem [brbf_pkg::DEPTH];
  logic [brbf_pkg::DATA_W-1:0] rd_data_q;

  logic [brbf_pkg::PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [brbf_pkg::PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [brbf_pkg::OCC_W-1:0]  occ_q, occ_d;
  logic [brbf_pkg::REQ_W-1:0]  grant_q, grant_d;
  logic [brbf_pkg::REM_W-1:0]  remain_q, remain_d;

  logic                        full;
  logic                        mem_we;
  logic [brbf_pkg::REQ_W-1:0]  req_sat;
  logic [brbf_pkg::REQ_W-1:0]  grant;

  logic                        out_valid_q;
  logic [brbf_pkg::DATA_W-1:0] read_byte_q, read_byte_d;
  logic                        byte_valid_q, byte_valid_d;
  logic                        last_q, last_d;
  logic                        accepted_q, accepted_d;
  logic [brbf_pkg::REQ_W-1:0]  moved_q, moved_d;
  logic [brbf_pkg::CNT_W-1:0]  stored_q, stored_d;

  assign full   = (occ_q == brbf_pkg::OCC_W'(brbf_pkg::DEPTH));
  assign mem_we = cmd_i.do_write && !full;

  // Saturate the request, then limit it to what is stored
  always_comb begin
    req_sat = (read_count_i > brbf_pkg::REQ_W'(brbf_pkg::MAX_BURST))
            ? brbf_pkg::REQ_W'(brbf_pkg::MAX_BURST) : read_count_i;
    if (brbf_pkg::CMP_W'(occ_q) < brbf_pkg::CMP_W'(req_sat)) begin
      grant = brbf_pkg::REQ_W'(occ_q);
    end else begin
      grant = req_sat;
    end
  end

  assign status_o.slot_free   = !out_valid_q || out_ready_i;
  assign status_o.grant_zero  = (grant == '0);
  assign status_o.remain_zero = (remain_q == '0);

  // Store written bytes and fetch the oldest one through a registered port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_ptr_q] <= data_byte_i;
    end
    if (cmd_i.do_fetch) begin
      rd_data_q <= mem[rd_ptr_q];
    end
  end

  // Advance pointers, occupancy and burst counters
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    occ_d    = occ_q;
    grant_d  = grant_q;
    remain_d = remain_q;
    if (cmd_i.do_clear) begin
      wr_ptr_d = '0;
      rd_ptr_d = '0;
      occ_d    = '0;
    end else if (mem_we) begin
      wr_ptr_d = brbf_pkg::next_ptr(wr_ptr_q);
      occ_d    = occ_q + brbf_pkg::OCC_W'(1);
    end else if (cmd_i.do_fetch) begin
      rd_ptr_d = brbf_pkg::next_ptr(rd_ptr_q);
      occ_d    = occ_q - brbf_pkg::OCC_W'(1);
    end
    if (cmd_i.start_read) begin
      grant_d  = grant;
      remain_d = brbf_pkg::REM_W'(grant - brbf_pkg::REQ_W'(1));
    end else if (cmd_i.do_fetch) begin
      remain_d = remain_q - brbf_pkg::REM_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      occ_q    <= '0;
      grant_q  <= '0;
      remain_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      occ_q    <= occ_d;
      grant_q  <= grant_d;
      remain_q <= remain_d;
    end
  end

  // Build the next result item
  always_comb begin
    read_byte_d  = '0;
    byte_valid_d = 1'b0;
    last_d       = 1'b1;
    accepted_d   = 1'b0;
    moved_d      = '0;
    stored_d     = brbf_pkg::CNT_W'(occ_q);
    unique case (cmd_i.out_kind)
      brbf_pkg::OK_WRITE: begin
        accepted_d = !full;
        stored_d   = full ? brbf_pkg::CNT_W'(occ_q)
                          : brbf_pkg::CNT_W'(occ_q + brbf_pkg::OCC_W'(1));
      end
      brbf_pkg::OK_CLEAR: begin
        stored_d = '0;
      end
      brbf_pkg::OK_BYTE: begin
        // occ_q already counts this byte as removed
        read_byte_d  = rd_data_q;
        byte_valid_d = 1'b1;
        last_d       = (remain_q == '0);
        moved_d      = grant_q;
      end
      brbf_pkg::OK_PLAIN: begin
        stored_d = brbf_pkg::CNT_W'(occ_q);
      end
      default: stored_d = brbf_pkg::CNT_W'(occ_q);
    endcase
  end

  // Hold the result until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      read_byte_q  <= read_byte_d;
      byte_valid_q <= byte_valid_d;
      last_q       <= last_d;
      accepted_q   <= accepted_d;
      moved_q      <= moved_d;
      stored_q     <= stored_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign read_byte_o    = read_byte_q;
  assign byte_valid_o   = byte_valid_q;
  assign last_o         = last_q;
  assign accepted_o     = accepted_q;
  assign moved_count_o  = moved_q;
  assign stored_count_o = stored_q;

endmodule

`default_nettype wire

// ----- rtl/byte_ring_buffer_fifo.sv -----
// Top level of the byte ring buffer FIFO: controller, datapath and channel ports.
// Depends on brbf_pkg, brbf_if, brbf_ctrl and brbf_dp.
`default_nettype none

// A circular byte FIFO of brbf_pkg::DEPTH entries. Write, clear and status items
// each give one result item; a new item is taken as soon as the output register
// is free or being emptied. A read burst granting n bytes (n is the request,
// capped at brbf_pkg::MAX_BURST, and at the occupancy) first fetches through the
// registered read port of the byte memory, then emits one byte per cycle while
// the output register is free or being emptied, with the next fetch overlapping
// each emitted byte. No item is taken while a burst runs. A write to a full
// buffer drops the byte and reports accepted = 0. The memory needs no clearing
// pass after reset.
module byte_ring_buffer_fifo (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  brbf_in_if.sink      in_i,
  brbf_out_if.source   out_o
);

  brbf_pkg::ctrl_cmd_t  cmd;
  brbf_pkg::dp_status_t status;

  brbf_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_command_i (in_i.command),
    .in_ready_o   (in_i.ready),
    .status_i     (status),
    .cmd_o        (cmd)
  );

  brbf_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .data_byte_i    (in_i.data_byte),
    .read_count_i   (in_i.read_count),
    .out_ready_i    (out_o.ready),
    .out_valid_o    (out_o.valid),
    .read_byte_o    (out_o.read_byte),
    .byte_valid_o   (out_o.byte_valid),
    .last_o         (out_o.last),
    .accepted_o     (out_o.accepted),
    .moved_count_o  (out_o.moved_count),
    .stored_count_o (out_o.stored_count)
  );

endmodule

`default_nettype wire

// ----- rtl/brbf_checker.sv -----
// Port-level checker for the byte ring buffer FIFO, bound to the top level.
// Depends on brbf_pkg for widths and command codes.
`default_nettype none

module brbf_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_valid_i,
  input wire logic                        in_ready_i,
  input wire logic [brbf_pkg::CMD_W-1:0]  in_command_i,
  input wire logic                        out_valid_i,
  input wire logic                        out_ready_i,
  input wire logic [brbf_pkg::DATA_W-1:0] read_byte_i,
  input wire logic                        byte_valid_i,
  input wire logic                        last_i,
  input wire logic                        accepted_i,
  input wire logic [brbf_pkg::REQ_W-1:0]  moved_count_i,
  input wire logic [brbf_pkg::CNT_W-1:0]  stored_count_i
);

  // Hold a stalled result item's valid, byte, last flag and stored count unchanged
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(read_byte_i)
      && $stable(last_i) && $stable(stored_count_i))
    else $error("stalled result item changed");

  // A byte item belongs to a granted burst and never reports a write
  a_byte_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && byte_valid_i |-> (moved_count_i != '0) && !accepted_i)
    else $error("byte item with zero grant or write flag");

  // An item without a byte is a single final item with zero data
  a_plain_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !byte_valid_i |-> last_i && (read_byte_i == '0)
      && (moved_count_i == '0))
    else $error("non-byte item malformed");

  // A clear yields an empty-buffer result in the next cycle
  a_clear_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_command_i == brbf_pkg::CMD_CLEAR)
      |=> out_valid_i && (stored_count_i == '0) && !byte_valid_i)
    else $error("clear did not report an empty buffer");

endmodule

bind byte_ring_buffer_fifo brbf_checker u_brbf_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .in_command_i   (in_i.command),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .read_byte_i    (out_o.read_byte),
  .byte_valid_i   (out_o.byte_valid),
  .last_i         (out_o.last),
  .accepted_i     (out_o.accepted),
  .moved_count_i  (out_o.moved_count),
  .stored_count_i (out_o.stored_count)
);

`default_nettype wire

// ----- sim/tb_byte_ring_buffer_fifo.sv -----
// Self-checking testbench for the byte ring buffer FIFO: directed table and random
// command traffic with drain pauses, scored by a cycle-free ring model or fixed rows.
// Depends on brbf_pkg, brbf_if and the byte_ring_buffer_fifo top level.
module tb_byte_ring_buffer_fifo;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned TAIL_CYCLES = 20;
  localparam int unsigned PLAN_LEN    = 24;

  typedef struct packed {
    logic [brbf_pkg::DATA_W-1:0] read_byte;
    logic                        byte_valid;
    logic                        last;
    logic                        accepted;
    logic [brbf_pkg::REQ_W-1:0]  moved_count;
    logic [brbf_pkg::CNT_W-1:0]  stored_count;
  } fifo_result_t;

  typedef struct {
    brbf_pkg::cmd_e              cmd;
    logic [brbf_pkg::DATA_W-1:0] data;
    logic [brbf_pkg::REQ_W-1:0]  count;
    bit                          fixed;
    fifo_result_t                want;
  } plan_row_t;

  logic clk_i;
  logic rst_n;

  brbf_in_if  cmd_if ();
  brbf_out_if res_if ();

  byte_ring_buffer_fifo uut (
    .clk_i  (clk_i),
    .rst_ni (rst_n),
    .in_i   (cmd_if),
    .out_o  (res_if)
  );

  // Shadow copy of the ring
  logic [brbf_pkg::DATA_W-1:0] ring_mem [brbf_pkg::DEPTH];
  logic [brbf_pkg::PTR_W-1:0]  ring_wr_ptr;
  logic [brbf_pkg::PTR_W-1:0]  ring_rd_ptr;
  int unsigned                 ring_fill;
  fifo_result_t                ring_results_q [$];

  int unsigned  items_taken;
  int unsigned  fail_count;
  int unsigned  quiet_cycles;
  int unsigned  tx_idle_pct;
  int unsigned  rx_idle_pct;
  bit           drive_fixed;
  fifo_result_t drive_want;
  plan_row_t    plan_rows [PLAN_LEN];

  function automatic fifo_result_t mk_result(input logic [brbf_pkg::DATA_W-1:0] b,
                                             input logic v, input logic l, input logic a,
                                             input logic [brbf_pkg::REQ_W-1:0] m,
                                             input logic [brbf_pkg::CNT_W-1:0] s);
    fifo_result_t r;
    r.read_byte    = b;
    r.byte_valid   = v;
    r.last         = l;
    r.accepted     = a;
    r.moved_count  = m;
    r.stored_count = s;
    return r;
  endfunction

  // Apply one command to the shadow ring and queue the result items it owes
  function automatic void ring_apply(input brbf_pkg::cmd_e cmd,
                                     input logic [brbf_pkg::DATA_W-1:0] data,
                                     input logic [brbf_pkg::REQ_W-1:0] count);
    fifo_result_t r;
    int unsigned  grant;
    r      = '0;
    r.last = 1'b1;
    case (cmd)
      brbf_pkg::CMD_WRITE: begin
        if (ring_fill < brbf_pkg::DEPTH) begin
          ring_mem[ring_wr_ptr] = data;
          ring_wr_ptr = brbf_pkg::next_ptr(ring_wr_ptr);
          ring_fill++;
          r.accepted = 1'b1;
        end
        r.stored_count = brbf_pkg::CNT_W'(ring_fill);
        ring_results_q.push_back(r);
      end
      brbf_pkg::CMD_READ: begin
        grant = (32'(count) > brbf_pkg::MAX_BURST) ? brbf_pkg::MAX_BURST : 32'(count);
        if (grant > ring_fill) begin
          grant = ring_fill;
        end
        if (grant == 0) begin
          r.stored_count = brbf_pkg::CNT_W'(ring_fill);
          ring_results_q.push_back(r);
        end else begin
          for (int unsigned i = 0; i < grant; i++) begin
            r.read_byte    = ring_mem[ring_rd_ptr];
            ring_rd_ptr    = brbf_pkg::next_ptr(ring_rd_ptr);
            ring_fill--;
            r.byte_valid   = 1'b1;
            r.last         = (i + 1 == grant);
            r.moved_count  = brbf_pkg::REQ_W'(grant);
            r.stored_count = brbf_pkg::CNT_W'(ring_fill);
            ring_results_q.push_back(r);
          end
        end
      end
      brbf_pkg::CMD_CLEAR: begin
        ring_wr_ptr = '0;
        ring_rd_ptr = '0;
        ring_fill   = 0;
        ring_results_q.push_back(r);
      end
      default: begin
        r.stored_count = brbf_pkg::CNT_W'(ring_fill);
        ring_results_q.push_back(r);
      end
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Receiver back-pressure
  always @(negedge clk_i) begin
    res_if.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Score both channels at the rising edge
  always @(posedge clk_i) begin
    fifo_result_t want;
    fifo_result_t got;
    if (rst_n) begin
      quiet_cycles++;
      if (cmd_if.valid && cmd_if.ready) begin
        ring_apply(brbf_pkg::cmd_e'(cmd_if.command), cmd_if.data_byte, cmd_if.read_count);
        // Rows with a hand-written result replace the modelled one
        if (drive_fixed) begin
          void'(ring_results_q.pop_back());
          ring_results_q.push_back(drive_want);
        end
        items_taken++;
        quiet_cycles = 0;
      end
      if (res_if.valid && res_if.ready) begin
        quiet_cycles = 0;
        got = mk_result(res_if.read_byte, res_if.byte_valid, res_if.last, res_if.accepted,
                        res_if.moved_count, res_if.stored_count);
        if (ring_results_q.size() == 0) begin
          $error("result item with none outstanding: stored_count %0d", got.stored_count);
          fail_count++;
        end else begin
          want = ring_results_q.pop_front();
          check_field("read_byte", 32'(want.read_byte), 32'(got.read_byte));
          check_field("byte_valid", 32'(want.byte_valid), 32'(got.byte_valid));
          check_field("last", 32'(want.last), 32'(got.last));
          check_field("accepted", 32'(want.accepted), 32'(got.accepted));
          check_field("moved_count", 32'(want.moved_count), 32'(got.moved_count));
          check_field("stored_count", 32'(want.stored_count), 32'(got.stored_count));
        end
      end
      // Stall watchdog
      if (quiet_cycles >= STALL_LIMIT) begin
        $error("no item moved for %0d cycles", STALL_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Present one command item, with random idle cycles ahead of it, and hold it until taken
  task automatic send_item(input brbf_pkg::cmd_e cmd,
                           input logic [brbf_pkg::DATA_W-1:0] data,
                           input logic [brbf_pkg::REQ_W-1:0] count, input bit fixed,
                           input fifo_result_t want);
    int unsigned target;
    target = items_taken + 1;
    while ($urandom_range(99) < tx_idle_pct) begin
      cmd_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    drive_fixed = fixed;
    drive_want  = want;
    cmd_if.valid      <= 1'b1;
    cmd_if.command    <= cmd;
    cmd_if.data_byte  <= data;
    cmd_if.read_count <= count;
    while (items_taken < target) begin
      @(negedge clk_i);
    end
  endtask

  // Lower valid and hold off until every owed result has come back
  task automatic drain_results();
    cmd_if.valid <= 1'b0;
    while (ring_results_q.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  // Random traffic: mostly write runs and read bursts, some status, clear and noise
  task automatic run_traffic(input int unsigned n_items);
    int unsigned issued;
    int unsigned pick;
    int unsigned run_len;
    issued = 0;
    while (issued < n_items) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        run_len = $urandom_range(1, 12);
        repeat (run_len) begin
          send_item(brbf_pkg::CMD_WRITE, brbf_pkg::DATA_W'($urandom),
                    brbf_pkg::REQ_W'($urandom), 1'b0, '0);
        end
        issued += run_len;
      end else if (pick < 75) begin
        if ($urandom_range(99) < 70) begin
          send_item(brbf_pkg::CMD_READ, brbf_pkg::DATA_W'($urandom),
                    brbf_pkg::REQ_W'($urandom_range(1, 16)), 1'b0, '0);
        end else begin
          send_item(brbf_pkg::CMD_READ, brbf_pkg::DATA_W'($urandom),
                    brbf_pkg::REQ_W'($urandom_range(0, 127)), 1'b0, '0);
        end
        issued++;
      end else if (pick < 85) begin
        send_item(brbf_pkg::CMD_STATUS, brbf_pkg::DATA_W'($urandom),
                  brbf_pkg::REQ_W'($urandom), 1'b0, '0);
        issued++;
      end else if (pick < 90) begin
        send_item(brbf_pkg::CMD_CLEAR, brbf_pkg::DATA_W'($urandom),
                  brbf_pkg::REQ_W'($urandom), 1'b0, '0);
        issued++;
      end else begin
        send_item(brbf_pkg::cmd_e'($urandom_range(3)), brbf_pkg::DATA_W'($urandom),
                  brbf_pkg::REQ_W'($urandom), 1'b0, '0);
        issued++;
      end
    end
  endtask

  // Main sequence
  initial begin
    rst_n             = 1'b0;
    cmd_if.valid      = 1'b0;
    cmd_if.command    = brbf_pkg::CMD_STATUS;
    cmd_if.data_byte  = '0;
    cmd_if.read_count = '0;
    res_if.ready      = 1'b0;
    ring_wr_ptr       = '0;
    ring_rd_ptr       = '0;
    ring_fill         = 0;
    items_taken       = 0;
    fail_count        = 0;
    quiet_cycles      = 0;
    drive_fixed       = 1'b0;
    drive_want        = '0;
    tx_idle_pct       = 37;
    rx_idle_pct       = 84;

    // Directed rows: empty reads, extremes of the fields, clear, request above the burst cap
    plan_rows = '{
      '{brbf_pkg::CMD_STATUS, 8'h00, 7'd0,   1'b1,
        mk_result(8'h00, 1'b0, 1'b1, 1'b0, 7'd0, 9'd0)},
      '{brbf_pkg::CMD_READ,   8'h00, 7'd5,   1'b1,
        mk_result(8'h00, 1'b0, 1'b1, 1'b0, 7'd0, 9'd0)},
      '{brbf_pkg::CMD_WRITE,  8'h00, 7'd0,   1'b1,
        mk_result(8'h00, 1'b0, 1'b1, 1'b1, 7'd0, 9'd1)},
      '{brbf_pkg::CMD_WRITE,  8'hFF, 7'd0,   1'b1,
        mk_result(8'h00, 1'b0, 1'b1, 1'b1, 7'd0, 9'd2)},
      '{brbf_pkg::CMD_WRITE,  8'hA5, 7'd0,   1'b1,
        mk_result(8'h00, 1'b0, 1'b1, 1'b1, 7'd0, 9'd3)},
      '{brbf_pkg::CMD_WRITE,  8'h5A, 7'd0,   1'b1,
        mk_result(8'h00, 1'b0, 1'b1, 1'b1, 7'd0, 9'd4)},
      '{brbf_pkg::CMD_READ,   8'h00, 7'd0,   1'b1,
        mk_result(8'h00, 1'b0, 1'b1, 1'b0, 7'd0, 9'd4)},
      '{brbf_pkg::CMD_READ,   8'h00, 7'd2,   1'b0, '0},
      '{brbf_pkg::CMD_STATUS, 8'h00, 7'd0,   1'b1,
        mk_result(8'h00, 1'b0, 1'b1, 1'b0, 7'd0, 9'd2)},
      '{brbf_pkg::CMD_READ,   8'h00, 7'd127, 1'b0, '0},
      '{brbf_pkg::CMD_READ,   8'h00, 7'd64,  1'b1,
        mk_result(8'h00, 1'b0, 1'b1, 1'b0, 7'd0, 9'd0)},
      '{brbf_pkg::CMD_WRITE,  8'h3C, 7'd0,   1'b1,
        mk_result(8'h00, 1'b0, 1'b1, 1'b1, 7'd0, 9'd1)},
      '{brbf_pkg::CMD_WRITE,  8'hC3, 7'd0,   1'b1,
        mk_result(8'h00, 1'b0, 1'b1, 1'b1, 7'd0, 9'd2)},
      '{brbf_pkg::CMD_CLEAR,  8'h00, 7'd0,   1'b1,
        mk_result(8'h00, 1'b0, 1'b1, 1'b0, 7'd0, 9'd0)},
      '{brbf_pkg::CMD_READ,   8'h00, 7'd1,   1'b1,
        mk_result(8'h00, 1'b0, 1'b1, 1'b0, 7'd0, 9'd0)},
      '{brbf_pkg::CMD_STATUS, 8'h00, 7'd0,   1'b1,
        mk_result(8'h00, 1'b0, 1'b1, 1'b0, 7'd0, 9'd0)},
      '{brbf_pkg::CMD_WRITE,  8'h81, 7'd0,   1'b1,
        mk_result(8'h00, 1'b0, 1'b1, 1'b1, 7'd0, 9'd1)},
      '{brbf_pkg::CMD_WRITE,  8'h7E, 7'd0,   1'b1,
        mk_result(8'h00, 1'b0, 1'b1, 1'b1, 7'd0, 9'd2)},
      '{brbf_pkg::CMD_READ,   8'h00, 7'd1,   1'b0, '0},
      '{brbf_pkg::CMD_READ,   8'h00, 7'd1,   1'b0, '0},
      '{brbf_pkg::CMD_READ,   8'h00, 7'd1,   1'b1,
        mk_result(8'h00, 1'b0, 1'b1, 1'b0, 7'd0, 9'd0)},
      '{brbf_pkg::CMD_WRITE,  8'h55, 7'd127, 1'b1,
        mk_result(8'h00, 1'b0, 1'b1, 1'b1, 7'd0, 9'd1)},
      '{brbf_pkg::CMD_CLEAR,  8'hFF, 7'd127, 1'b1,
        mk_result(8'h00, 1'b0, 1'b1, 1'b0, 7'd0, 9'd0)},
      '{brbf_pkg::CMD_STATUS, 8'hAA, 7'd42,  1'b1,
        mk_result(8'h00, 1'b0, 1'b1, 1'b0, 7'd0, 9'd0)}
    };

    // Hold reset low, then release it
    repeat (3) @(negedge clk_i);
    rst_n <= 1'b1;
    @(negedge clk_i);

    // Sender idles often, receiver idles more
    foreach (plan_rows[i]) begin
      send_item(plan_rows[i].cmd, plan_rows[i].data, plan_rows[i].count,
                plan_rows[i].fixed, plan_rows[i].want);
    end
    run_traffic(52);
    drain_results();

    // Roles swapped
    tx_idle_pct = 84;
    rx_idle_pct = 37;
    run_traffic(52);
    drain_results();

    // No idling on either side
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_traffic(52);
    drain_results();
    repeat (TAIL_CYCLES) @(negedge clk_i);

    if (ring_results_q.size() != 0) begin
      $error("%0d result items never arrived", ring_results_q.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
